[rtl/fbpa_pkg.sv]
// Shared constants, codes and a helper for the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int POOL_DEPTH  = 64;
    localparam int IDX_W       = $clog2(POOL_DEPTH);
    localparam int CNT_W       = $clog2(POOL_DEPTH + 1);

    localparam int CFG_W       = 7;
    localparam int CHUNK_IDX_W = 8;
    localparam int GUARD_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int GRANT_W     = 6;
    localparam int TOTAL_W     = 7;

    localparam logic [CFG_W-1:0]   CHUNK_COUNT_RESET = 7'd64;
    localparam logic [GUARD_W-1:0] GUARD_VALUE       = 32'hdeadbeef;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_REINIT = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_EMPTY     = 3'd1,
        STS_BAD_INDEX = 3'd2,
        STS_GUARD     = 3'd3,
        STS_BUSY      = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_APPEND = 4'b0100,
        ST_SWEEP  = 4'b1000
    } state_t;

    // chunk_count clamped to 1..POOL_DEPTH
    function automatic logic [CNT_W-1:0] sat_count(input logic [CFG_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (32'(c) > POOL_DEPTH) begin
            r = CNT_W'(POOL_DEPTH);
        end else begin
            r = CNT_W'(c);
        end
        return r;
    endfunction

endpackage

[rtl/fbpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/fixed_block_pool_allocator_unit.sv]
// Top level of the fixed block pool allocator: free-list control over link RAMs.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------------
//  input    | s_valid/s_ready  | s_command, s_chunk_index, s_guard_word, s_force_req
//  result   | m_valid/m_ready  | m_status, m_granted_index, m_free_total, m_used_total
//  config   | cfg_we           | cfg_wdata (chunk_count)
//
// Allocate and rejected commands finish in the execute step after the RAM read; a good
// free runs RAM read, unlink and append as separate steps, set by the one write port on each link RAM.
// A successful reinitialize is followed by a rebuild sweep over all POOL_DEPTH (64) entries.
// After reset the same sweep runs before the first transaction is taken.
// A transaction is taken while a result still waits; it stalls at its last step only
// when the result register is full and m_ready is low.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [fbpa_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_command,
    input  logic [fbpa_pkg::CHUNK_IDX_W-1:0]    s_chunk_index,
    input  logic [fbpa_pkg::GUARD_W-1:0]        s_guard_word,
    input  logic                                s_force_req,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]       m_status,
    output logic [fbpa_pkg::GRANT_W-1:0]        m_granted_index,
    output logic [fbpa_pkg::TOTAL_W-1:0]        m_free_total,
    output logic [fbpa_pkg::TOTAL_W-1:0]        m_used_total
);

    localparam int IDX_W = fbpa_pkg::IDX_W;
    localparam int CNT_W = fbpa_pkg::CNT_W;

    fbpa_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] sweep_idx_reg, sweep_idx_next;
    logic [fbpa_pkg::CFG_W-1:0] chunk_count_reg, chunk_count_next;
    logic [CNT_W-1:0] active_size_reg, active_size_next;
    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [IDX_W-1:0] free_tail_reg, free_tail_next;
    logic [CNT_W-1:0] free_level_reg, free_level_next;
    logic [CNT_W-1:0] used_level_reg, used_level_next;

    fbpa_pkg::cmd_t cmd_reg, cmd_next;
    logic [fbpa_pkg::CHUNK_IDX_W-1:0] idx_reg, idx_next;
    logic guard_ok_reg, guard_ok_next;
    logic force_reg, force_next;

    logic m_valid_reg, m_valid_next;
    fbpa_pkg::status_t m_status_reg, m_status_next;
    logic [IDX_W-1:0] m_granted_reg, m_granted_next;
    logic [CNT_W-1:0] m_free_reg, m_free_next;
    logic [CNT_W-1:0] m_used_reg, m_used_next;

    // link / mark RAM ports
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             nxt_we, prv_we, mrk_we;
    logic [IDX_W-1:0] nxt_waddr, prv_waddr, mrk_waddr;
    logic [IDX_W-1:0] nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;
    logic             mrk_wdata, mrk_rdata;

    logic                finish;
    fbpa_pkg::status_t   res_status;
    logic [IDX_W-1:0]    res_grant;
    logic                fin_ok;
    logic                idx_ok;
    logic [IDX_W-1:0]    idx_lo;
    logic [CNT_W-1:0]    new_size;
    logic [CNT_W-1:0]    reset_size;

    fbpa_ram #(.WIDTH(IDX_W), .DEPTH(fbpa_pkg::POOL_DEPTH)) u_next_ram (
        .aclk (aclk), .we (nxt_we), .waddr (nxt_waddr), .wdata (nxt_wdata),
        .re (rd_en), .raddr (rd_addr), .rdata (nxt_rdata)
    );

    fbpa_ram #(.WIDTH(IDX_W), .DEPTH(fbpa_pkg::POOL_DEPTH)) u_prev_ram (
        .aclk (aclk), .we (prv_we), .waddr (prv_waddr), .wdata (prv_wdata),
        .re (rd_en), .raddr (rd_addr), .rdata (prv_rdata)
    );

    fbpa_ram #(.WIDTH(1), .DEPTH(fbpa_pkg::POOL_DEPTH)) u_mark_ram (
        .aclk (aclk), .we (mrk_we), .waddr (mrk_waddr), .wdata (mrk_wdata),
        .re (rd_en), .raddr (rd_addr), .rdata (mrk_rdata)
    );

    assign s_ready = (state_reg == fbpa_pkg::ST_IDLE);
    assign rd_en   = s_valid && s_ready;
    assign rd_addr = (s_command == fbpa_pkg::CMD_ALLOC) ? free_head_reg
                                                        : s_chunk_index[IDX_W-1:0];

    assign fin_ok     = !m_valid_reg || m_ready;
    assign idx_ok     = 32'(idx_reg) < 32'(active_size_reg);
    assign idx_lo     = idx_reg[IDX_W-1:0];
    assign new_size   = fbpa_pkg::sat_count(chunk_count_reg);
    assign reset_size = fbpa_pkg::sat_count(fbpa_pkg::CHUNK_COUNT_RESET);

    assign chunk_count_next = cfg_we ? cfg_wdata : chunk_count_reg;

    always_comb begin
        state_next       = state_reg;
        sweep_idx_next   = sweep_idx_reg;
        active_size_next = active_size_reg;
        free_head_next   = free_head_reg;
        free_tail_next   = free_tail_reg;
        free_level_next  = free_level_reg;
        used_level_next  = used_level_reg;
        cmd_next         = cmd_reg;
        idx_next         = idx_reg;
        guard_ok_next    = guard_ok_reg;
        force_next       = force_reg;
        nxt_we = 1'b0;  nxt_waddr = '0;  nxt_wdata = '0;
        prv_we = 1'b0;  prv_waddr = '0;  prv_wdata = '0;
        mrk_we = 1'b0;  mrk_waddr = '0;  mrk_wdata = 1'b0;
        finish     = 1'b0;
        res_status = fbpa_pkg::STS_OK;
        res_grant  = '0;

        case (state_reg)
            fbpa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd_next      = fbpa_pkg::cmd_t'(s_command);
                    idx_next      = s_chunk_index;
                    guard_ok_next = (s_guard_word == fbpa_pkg::GUARD_VALUE);
                    force_next    = s_force_req;
                    state_next    = fbpa_pkg::ST_EXEC;
                end
            end

            fbpa_pkg::ST_EXEC: begin
                case (cmd_reg)
                    fbpa_pkg::CMD_ALLOC: begin
                        if (fin_ok) begin
                            finish     = 1'b1;
                            state_next = fbpa_pkg::ST_IDLE;
                            if (free_level_reg == '0) begin
                                res_status = fbpa_pkg::STS_EMPTY;
                            end else begin
                                free_head_next = nxt_rdata;
                                if (free_head_reg == free_tail_reg) begin
                                    free_tail_next = prv_rdata;
                                end else begin
                                    prv_we    = 1'b1;
                                    prv_waddr = nxt_rdata;
                                    prv_wdata = prv_rdata;
                                end
                                free_level_next = free_level_reg - CNT_W'(1);
                                mrk_we          = 1'b1;
                                mrk_waddr       = free_head_reg;
                                mrk_wdata       = 1'b1;
                                used_level_next = used_level_reg + CNT_W'(1);
                                res_grant       = free_head_reg;
                            end
                        end
                    end

                    fbpa_pkg::CMD_FREE: begin
                        if (!idx_ok || !guard_ok_reg) begin
                            if (fin_ok) begin
                                finish     = 1'b1;
                                state_next = fbpa_pkg::ST_IDLE;
                                res_status = !idx_ok ? fbpa_pkg::STS_BAD_INDEX
                                                     : fbpa_pkg::STS_GUARD;
                            end
                        end else begin
                            // first half: drop the mark or unlink; append follows
                            state_next = fbpa_pkg::ST_APPEND;
                            if (mrk_rdata) begin
                                mrk_we    = 1'b1;
                                mrk_waddr = idx_lo;
                                mrk_wdata = 1'b0;
                                if (used_level_reg != '0) begin
                                    used_level_next = used_level_reg - CNT_W'(1);
                                end
                            end else begin
                                if (idx_lo == free_head_reg) begin
                                    free_head_next = nxt_rdata;
                                end else begin
                                    nxt_we    = 1'b1;
                                    nxt_waddr = prv_rdata;
                                    nxt_wdata = nxt_rdata;
                                end
                                if (idx_lo == free_tail_reg) begin
                                    free_tail_next = prv_rdata;
                                end else begin
                                    prv_we    = 1'b1;
                                    prv_waddr = nxt_rdata;
                                    prv_wdata = prv_rdata;
                                end
                                if (free_level_reg != '0) begin
                                    free_level_next = free_level_reg - CNT_W'(1);
                                end
                            end
                        end
                    end

                    fbpa_pkg::CMD_REINIT: begin
                        if (fin_ok) begin
                            finish = 1'b1;
                            if (!force_reg && used_level_reg != '0) begin
                                res_status = fbpa_pkg::STS_BUSY;
                                state_next = fbpa_pkg::ST_IDLE;
                            end else begin
                                active_size_next = new_size;
                                free_head_next   = '0;
                                free_tail_next   = IDX_W'(new_size - CNT_W'(1));
                                free_level_next  = new_size;
                                used_level_next  = '0;
                                sweep_idx_next   = '0;
                                state_next       = fbpa_pkg::ST_SWEEP;
                            end
                        end
                    end

                    default: begin
                        if (fin_ok) begin
                            finish     = 1'b1;
                            state_next = fbpa_pkg::ST_IDLE;
                        end
                    end
                endcase
            end

            fbpa_pkg::ST_APPEND: begin
                if (fin_ok) begin
                    finish     = 1'b1;
                    state_next = fbpa_pkg::ST_IDLE;
                    if (free_level_reg == '0) begin
                        free_head_next = idx_lo;
                    end else begin
                        nxt_we    = 1'b1;
                        nxt_waddr = free_tail_reg;
                        nxt_wdata = idx_lo;
                        prv_we    = 1'b1;
                        prv_waddr = idx_lo;
                        prv_wdata = free_tail_reg;
                    end
                    free_tail_next  = idx_lo;
                    free_level_next = free_level_reg + CNT_W'(1);
                end
            end

            fbpa_pkg::ST_SWEEP: begin
                // ascending chain over the active size, zero links elsewhere
                nxt_we    = 1'b1;
                nxt_waddr = sweep_idx_reg;
                nxt_wdata = ((CNT_W'(sweep_idx_reg) + CNT_W'(1)) < active_size_reg)
                            ? (sweep_idx_reg + IDX_W'(1)) : '0;
                prv_we    = 1'b1;
                prv_waddr = sweep_idx_reg;
                prv_wdata = (sweep_idx_reg != '0 && CNT_W'(sweep_idx_reg) < active_size_reg)
                            ? (sweep_idx_reg - IDX_W'(1)) : '0;
                mrk_we    = 1'b1;
                mrk_waddr = sweep_idx_reg;
                mrk_wdata = 1'b0;
                if (sweep_idx_reg == IDX_W'(fbpa_pkg::POOL_DEPTH - 1)) begin
                    state_next = fbpa_pkg::ST_IDLE;
                end else begin
                    sweep_idx_next = sweep_idx_reg + IDX_W'(1);
                end
            end

            default: begin
                state_next = fbpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_status_next  = m_status_reg;
        m_granted_next = m_granted_reg;
        m_free_next    = m_free_reg;
        m_used_next    = m_used_reg;
        if (finish) begin
            m_valid_next   = 1'b1;
            m_status_next  = res_status;
            m_granted_next = res_grant;
            m_free_next    = free_level_next;
            m_used_next    = used_level_next;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fbpa_pkg::ST_SWEEP;
            sweep_idx_reg   <= '0;
            chunk_count_reg <= fbpa_pkg::CHUNK_COUNT_RESET;
            active_size_reg <= reset_size;
            free_head_reg   <= '0;
            free_tail_reg   <= IDX_W'(reset_size - CNT_W'(1));
            free_level_reg  <= reset_size;
            used_level_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            sweep_idx_reg   <= sweep_idx_next;
            chunk_count_reg <= chunk_count_next;
            active_size_reg <= active_size_next;
            free_head_reg   <= free_head_next;
            free_tail_reg   <= free_tail_next;
            free_level_reg  <= free_level_next;
            used_level_reg  <= used_level_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        guard_ok_reg   <= guard_ok_next;
        force_reg      <= force_next;
        m_status_reg   <= m_status_next;
        m_granted_reg  <= m_granted_next;
        m_free_reg     <= m_free_next;
        m_used_reg     <= m_used_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_index = fbpa_pkg::GRANT_W'(m_granted_reg);
    assign m_free_total    = fbpa_pkg::TOTAL_W'(m_free_reg);
    assign m_used_total    = fbpa_pkg::TOTAL_W'(m_used_reg);

    // every chunk of the active pool is either free or in use; a free is one short
    // between its two halves
    a_level_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != fbpa_pkg::ST_APPEND) |->
        (((CNT_W + 1)'(free_level_reg) + (CNT_W + 1)'(used_level_reg))
            == (CNT_W + 1)'(active_size_reg)))
        else $error("free and used counts do not cover the pool");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == fbpa_pkg::ST_EXEC))
        else $error("accepted transaction did not start execution");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == fbpa_pkg::STS_EMPTY) |-> (m_free_total == '0))
        else $error("pool empty reported with free chunks left");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fbpa_pkg::ST_IDLE && free_level_reg != '0)
            |-> (CNT_W'(free_head_reg) < active_size_reg))
        else $error("free list head outside the active pool");

endmodule
